// ----- hdl/egcd_pkg.sv -----
// Shared constants and control types for the extended gcd block.
`timescale 1ns / 1ps

package egcd_pkg;

  // Default operand width.
  localparam int DATA_WIDTH_DEF = 32;

  // Sequencer to divider: start one Euclid step.
  typedef struct packed {
    logic start;
  } egcd_div_ctrl_t;

  // Divider to sequencer: busy while iterating, done for one cycle at the end.
  typedef struct packed {
    logic busy;
    logic done;
  } egcd_div_stat_t;

endpackage

// ----- hdl/egcd_if.sv -----
// Valid/ready channel interfaces for operand and result beats.
`timescale 1ns / 1ps

interface egcd_in_if #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] operand_a;
  logic signed [DATA_WIDTH-1:0] operand_b;

  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface egcd_out_if #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic        [DATA_WIDTH-2:0] gcd_result;
  logic signed [DATA_WIDTH-1:0] coef_a;
  logic signed [DATA_WIDTH-1:0] coef_b;
  logic                         input_error;

  modport source (output valid, output gcd_result, output coef_a, output coef_b,
                  output input_error, input ready);
  modport sink   (input valid, input gcd_result, input coef_a, input coef_b,
                  input input_error, output ready);
endinterface

// ----- hdl/egcd_div.sv -----
// Bit-serial restoring divider with quotient-times-coefficient accumulators.
`timescale 1ns / 1ps

module egcd_div #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  egcd_pkg::egcd_div_ctrl_t  ctrl,
  input  logic [DATA_WIDTH-1:0]     dividend,
  input  logic [DATA_WIDTH-1:0]     divisor,
  input  logic [DATA_WIDTH-1:0]     s1,
  input  logic [DATA_WIDTH-1:0]     t1,
  output egcd_pkg::egcd_div_stat_t  stat,
  output logic [DATA_WIDTH-1:0]     rem,
  output logic [DATA_WIDTH-1:0]     qs,
  output logic [DATA_WIDTH-1:0]     qt
);
  import egcd_pkg::*;

  localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [DATA_WIDTH-1:0] dvd_r, dvd_nxt;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] qs_r, qs_nxt;
  logic [DATA_WIDTH-1:0] qt_r, qt_nxt;
  logic [DATA_WIDTH:0]   trial;
  logic                  qbit;

  // Shift in the next dividend bit and try the subtract.
  assign trial = {rem_r, dvd_r[DATA_WIDTH-1]} - {1'b0, divisor};
  assign qbit  = ~trial[DATA_WIDTH];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    qs_nxt   = qs_r;
    qt_nxt   = qt_r;
    if (ctrl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      qs_nxt   = '0;
      qt_nxt   = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DATA_WIDTH-2:0], 1'b0};
      rem_nxt = qbit ? trial[DATA_WIDTH-1:0] : {rem_r[DATA_WIDTH-2:0], dvd_r[DATA_WIDTH-1]};
      // Horner form, quotient MSB first: acc = 2*acc + qbit*coef.
      qs_nxt  = {qs_r[DATA_WIDTH-2:0], 1'b0} + (qbit ? s1 : '0);
      qt_nxt  = {qt_r[DATA_WIDTH-2:0], 1'b0} + (qbit ? t1 : '0);
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(DATA_WIDTH - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    qs_r  <= qs_nxt;
    qt_r  <= qt_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign rem       = rem_r;
  assign qs        = qs_r;
  assign qt        = qt_r;

endmodule

// ----- hdl/extended_gcd.sv -----
// Extended Euclid gcd: one operand pair in, gcd and Bezout coefficients out.
// One operand beat is taken at a time; in_ch.ready is high only while the block is idle.
// After acceptance the block runs Euclid steps on the larger operand as dividend,
// each step starting the one-bit-per-cycle restoring divider (which also builds
// q*s and q*t bit by bit) from ST_LOOP and folding its results back in ST_DIV.
// For 32-bit operands the number of steps is at most 44 (neighboring Fibonacci
// numbers). A negative operand or two zero operands raise out_ch.valid at the
// accepting edge itself, and a single zero operand after one pass through ST_LOOP.
// The result beat is held in an output register until out_ch.ready takes it, and
// the next operand beat is taken only after that. Coefficients wrap modulo
// 2^DATA_WIDTH; on an input error all result fields are zero and input_error is set.
`timescale 1ns / 1ps

module extended_gcd #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  egcd_in_if.sink           in_ch,
  egcd_out_if.source        out_ch
);
  import egcd_pkg::*;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;  // wait for an operand beat
  localparam logic [1:0] ST_LOOP = 2'd1;  // test remainder, start a step or finish
  localparam logic [1:0] ST_DIV  = 2'd2;  // divider running
  localparam logic [1:0] ST_OUT  = 2'd3;  // result beat waiting

  logic [1:0]            state_r, state_nxt;
  logic [DATA_WIDTH-1:0] x_r, x_nxt;
  logic [DATA_WIDTH-1:0] y_r, y_nxt;
  logic [DATA_WIDTH-1:0] s0_r, s0_nxt;
  logic [DATA_WIDTH-1:0] s1_r, s1_nxt;
  logic [DATA_WIDTH-1:0] t0_r, t0_nxt;
  logic [DATA_WIDTH-1:0] t1_r, t1_nxt;
  logic                  swap_r, swap_nxt;

  logic [DATA_WIDTH-2:0] gcd_r, gcd_nxt;
  logic [DATA_WIDTH-1:0] ca_r, ca_nxt;
  logic [DATA_WIDTH-1:0] cb_r, cb_nxt;
  logic                  err_r, err_nxt;

  egcd_div_ctrl_t        div_ctrl;
  egcd_div_stat_t        div_stat;
  logic [DATA_WIDTH-1:0] div_rem;
  logic [DATA_WIDTH-1:0] div_qs;
  logic [DATA_WIDTH-1:0] div_qt;

  logic [DATA_WIDTH-1:0] a_in, b_in;
  logic                  in_bad;
  logic                  in_swap;

  assign a_in    = DATA_WIDTH'(in_ch.operand_a);
  assign b_in    = DATA_WIDTH'(in_ch.operand_b);
  assign in_bad  = a_in[DATA_WIDTH-1] | b_in[DATA_WIDTH-1] | ((a_in == '0) && (b_in == '0));
  assign in_swap = b_in > a_in;

  always_comb begin
    state_nxt      = state_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    s0_nxt         = s0_r;
    s1_nxt         = s1_r;
    t0_nxt         = t0_r;
    t1_nxt         = t1_r;
    swap_nxt       = swap_r;
    gcd_nxt        = gcd_r;
    ca_nxt         = ca_r;
    cb_nxt         = cb_r;
    err_nxt        = err_r;
    div_ctrl.start = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_bad) begin
            // Drop straight to an all-zero error beat.
            gcd_nxt   = '0;
            ca_nxt    = '0;
            cb_nxt    = '0;
            err_nxt   = 1'b1;
            state_nxt = ST_OUT;
          end else begin
            // Larger operand becomes the dividend.
            swap_nxt  = in_swap;
            x_nxt     = in_swap ? b_in : a_in;
            y_nxt     = in_swap ? a_in : b_in;
            s0_nxt    = DATA_WIDTH'(1);
            s1_nxt    = '0;
            t0_nxt    = '0;
            t1_nxt    = DATA_WIDTH'(1);
            state_nxt = ST_LOOP;
          end
        end
      end
      ST_LOOP: begin
        if (y_r == '0) begin
          // Remainder hit zero: x holds the gcd; swap coefficients back if needed.
          gcd_nxt   = x_r[DATA_WIDTH-2:0];
          ca_nxt    = swap_r ? t0_r : s0_r;
          cb_nxt    = swap_r ? s0_r : t0_r;
          err_nxt   = 1'b0;
          state_nxt = ST_OUT;
        end else begin
          div_ctrl.start = 1'b1;
          state_nxt      = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          // Advance the remainder pair and the coefficient pairs.
          x_nxt     = y_r;
          y_nxt     = div_rem;
          s0_nxt    = s1_r;
          s1_nxt    = s0_r - div_qs;
          t0_nxt    = t1_r;
          t1_nxt    = t0_r - div_qt;
          state_nxt = ST_LOOP;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    s0_r   <= s0_nxt;
    s1_r   <= s1_nxt;
    t0_r   <= t0_nxt;
    t1_r   <= t1_nxt;
    swap_r <= swap_nxt;
    gcd_r  <= gcd_nxt;
    ca_r   <= ca_nxt;
    cb_r   <= cb_nxt;
    err_r  <= err_nxt;
  end

  // Shared divide unit: x_r, y_r, s1_r and t1_r hold steady while it runs.
  egcd_div #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (x_r),
    .divisor  (y_r),
    .s1       (s1_r),
    .t1       (t1_r),
    .stat     (div_stat),
    .rem      (div_rem),
    .qs       (div_qs),
    .qt       (div_qt)
  );

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = (state_r == ST_OUT);
  assign out_ch.gcd_result  = gcd_r;
  assign out_ch.coef_a      = ca_r;
  assign out_ch.coef_b      = cb_r;
  assign out_ch.input_error = err_r;

endmodule

// ----- hdl/egcd_checker.sv -----
// Port-level checks for the extended gcd block, bound to its top level.
`timescale 1ns / 1ps

module egcd_checker #(
  parameter int DATA_WIDTH = egcd_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-2:0] gcd_result,
  input logic [DATA_WIDTH-1:0] coef_a,
  input logic [DATA_WIDTH-1:0] coef_b,
  input logic                  input_error
);
  import egcd_pkg::*;

  // One item in flight: never take operands while a result waits.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("operand beat possible while result pending");

  // Accepting operands closes the input side on the next edge.
  a_close_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input still open after accepted beat");

  // Error beats carry all-zero payload.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && input_error) |-> ((gcd_result == '0) && (coef_a == '0) && (coef_b == '0)))
    else $error("error beat with nonzero payload");

  // Good beats have a nonzero gcd.
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !input_error) |-> (gcd_result != '0))
    else $error("zero gcd without error");

  // Stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(gcd_result) && $stable(coef_a)
                                   && $stable(coef_b) && $stable(input_error)))
    else $error("stalled result beat changed");

endmodule

bind extended_gcd egcd_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_egcd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .gcd_result  (out_ch.gcd_result),
  .coef_a      (out_ch.coef_a),
  .coef_b      (out_ch.coef_b),
  .input_error (out_ch.input_error)
);
